// ----- src/mlec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mlec_pkg;

    // Defaults for the top-level parameters
    localparam int MaxDimDefault      = 128;
    localparam int SampleWidthDefault = 16;

    // Configuration port
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  SIZE_RESET   = 8'd128;

    // Result field
    localparam int TALLY_W    = 15;
    localparam int M_TDATA_W  = ((TALLY_W + 7) / 8) * 8;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // Per-sample position flags carried from the address stage to the window stage
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
        logic last_col;
        logic last_row;
    } pos_flags_t;

endpackage

`default_nettype wire

// ----- src/matrix_local_extremum_counter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Counts strict local maxima and minima (3x3 neighborhood, edges use only in-range
// neighbors, any equal neighbor disqualifies) of a num_rows x num_cols matrix of
// signed samples streamed in raster order. One sample is taken every cycle; the count
// beat passes the window stage into the output register after a matrix's last sample is
// accepted, then the next matrix starts. Input stalls only when a sample that closes a
// matrix finds the count register still occupied. The two previous rows live in one
// MAX_DIM-word RAM of 2*SAMPLE_WIDTH bits with a registered read; the window stage
// writes each column back as its beat leaves, and a read of the column still being
// written (single-column matrices) is forwarded. Size registers read as 0 mean 1 and
// above MAX_DIM mean MAX_DIM; the user must write them between matrices (not enforced).
module matrix_local_extremum_counter_top
    import mlec_pkg::*;
#(
    parameter int MAX_DIM      = MaxDimDefault,
    parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // sample input
    input  wire logic                                   s_tvalid,
    output      logic                                   s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,  // [SW-1:0] sample_value
    // count output
    output      logic                                   m_tvalid,
    input  wire logic                                   m_tready,
    output      logic [M_TDATA_W-1:0]                   m_tdata,  // [14:0] extremum_count
    // configuration writes
    input  wire logic                                   cfg_valid,
    output      logic                                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]                 cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                  cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int POS_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;

    // ---------------- configuration ----------------
    logic [CFG_DATA_W-1:0] num_rows_reg;
    logic [CFG_DATA_W-1:0] num_cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= SIZE_RESET;
            num_cols_reg <= SIZE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NUM_ROWS: num_rows_reg <= cfg_data;
                REG_NUM_COLS: num_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, clamp to MAX_DIM
    logic [CMP_W-1:0] rows_eff;
    logic [CMP_W-1:0] cols_eff;

    always_comb begin
        rows_eff = CMP_W'(num_rows_reg);
        if (rows_eff == '0) begin
            rows_eff = CMP_W'(1);
        end else if (rows_eff > CMP_W'(MAX_DIM)) begin
            rows_eff = CMP_W'(MAX_DIM);
        end
        cols_eff = CMP_W'(num_cols_reg);
        if (cols_eff == '0) begin
            cols_eff = CMP_W'(1);
        end else if (cols_eff > CMP_W'(MAX_DIM)) begin
            cols_eff = CMP_W'(MAX_DIM);
        end
    end

    // ---------------- address stage ----------------
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_reg;
    logic             s_accept;
    pos_flags_t       flags_in;

    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        flags_in.r_ge1    = row_reg != '0;
        flags_in.r_ge2    = CMP_W'(row_reg) >= CMP_W'(2);
        flags_in.c_ge1    = col_reg != '0;
        flags_in.c_ge2    = CMP_W'(col_reg) >= CMP_W'(2);
        flags_in.last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= cols_eff;
        flags_in.last_row = (CMP_W'(row_reg) + CMP_W'(1)) >= rows_eff;
    end

    // Raster position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (s_accept) begin
            if (flags_in.last_col) begin
                col_reg <= '0;
                row_reg <= flags_in.last_row ? '0 : row_reg + POS_W'(1);
            end else begin
                col_reg <= col_reg + POS_W'(1);
            end
        end
    end

    // ---------------- row store RAM: {middle, upper} ----------------
    logic             s1_valid_reg;
    logic             s1_fire;
    logic signed [SW-1:0] s1_x_reg;
    logic [POS_W-1:0] s1_col_reg;
    pos_flags_t       s1_flags_reg;
    logic [2*SW-1:0]  ram_rdata;
    logic [2*SW-1:0]  ram_wdata;
    logic             fwd_reg;
    logic [2*SW-1:0]  fwd_data_reg;
    logic [2*SW-1:0]  row_word;

    mlec_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_DIM)
    ) u_row_ram (
        .clk   (aclk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Forward the column being written when the next beat reads it back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_reg <= s1_valid_reg && (s1_col_reg == col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_data_reg <= ram_wdata;
        end
    end

    assign row_word  = fwd_reg ? fwd_data_reg : ram_rdata;

    // ---------------- window stage ----------------
    logic signed [SW-1:0] up_val;
    logic signed [SW-1:0] mid_val;
    logic signed [SW-1:0] win_reg [9];
    logic signed [SW-1:0] win_next [9];
    logic [2:0]           rv;
    logic [2:0]           cv;
    logic [3:0]           cell_en;
    logic [3:0]           cell_hit;
    logic                 s1_emit;
    logic                 out_valid_reg;
    logic [TALLY_W-1:0]   out_count_reg;
    logic [TALLY_W-1:0]   tally_reg;
    logic [TALLY_W-1:0]   tally_next;
    logic [2:0]           hit_cnt;
    logic [TALLY_W:0]     tally_sum;

    assign up_val    = row_word[SW-1:0];
    assign mid_val   = row_word[2*SW-1:SW];
    assign ram_wdata = {s1_x_reg, mid_val};

    // Shift the window left and bring in the new column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k*3+0] = win_reg[k*3+1];
            win_next[k*3+1] = win_reg[k*3+2];
        end
        win_next[2] = up_val;
        win_next[5] = mid_val;
        win_next[8] = s1_x_reg;
    end

    assign rv = {1'b1, s1_flags_reg.r_ge1, s1_flags_reg.r_ge2};
    assign cv = {1'b1, s1_flags_reg.c_ge1, s1_flags_reg.c_ge2};

    assign cell_en[0] = s1_flags_reg.r_ge1    && s1_flags_reg.c_ge1;
    assign cell_en[1] = s1_flags_reg.r_ge1    && s1_flags_reg.last_col;
    assign cell_en[2] = s1_flags_reg.last_row && s1_flags_reg.c_ge1;
    assign cell_en[3] = s1_flags_reg.last_row && s1_flags_reg.last_col;

    // Four candidate cells: window positions (1,1), (1,2), (2,1), (2,2)
    for (genvar g = 0; g < 4; g++) begin : g_cell
        localparam int CR = 1 + g / 2;
        localparam int CC = 1 + g % 2;
        logic signed [SW-1:0] nb [8];
        logic [7:0]           nm;

        for (genvar k = 0; k < 8; k++) begin : g_nb
            localparam int IDX = (k < 4) ? k : k + 1;
            localparam int NR  = CR + IDX / 3 - 1;
            localparam int NC  = CC + IDX % 3 - 1;
            if (NR <= 2 && NC <= 2) begin : g_in
                assign nb[k] = win_next[NR*3+NC];
                assign nm[k] = rv[NR] && cv[NC];
            end else begin : g_out
                assign nb[k] = '0;
                assign nm[k] = 1'b0;
            end
        end

        mlec_judge #(
            .SAMPLE_WIDTH (SW)
        ) u_judge (
            .center (win_next[CR*3+CC]),
            .nbr    (nb),
            .mask   (nm),
            .enable (cell_en[g]),
            .hit    (cell_hit[g])
        );
    end

    // Saturating tally
    always_comb begin
        hit_cnt = 3'(cell_hit[0]) + 3'(cell_hit[1]) + 3'(cell_hit[2]) + 3'(cell_hit[3]);
        tally_sum = (TALLY_W+1)'(tally_reg) + (TALLY_W+1)'(hit_cnt);
        tally_next = tally_sum[TALLY_W] ? TALLY_MAX : tally_sum[TALLY_W-1:0];
    end

    assign s1_emit  = s1_flags_reg.last_col && s1_flags_reg.last_row;
    assign s1_fire  = s1_valid_reg && !(s1_emit && out_valid_reg && !m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_x_reg     <= signed'(s_tdata[SW-1:0]);
            s1_col_reg   <= col_reg;
            s1_flags_reg <= flags_in;
        end
    end

    // Window and tally advance on each beat leaving the window stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
            tally_reg <= '0;
        end else if (s1_fire) begin
            win_reg   <= win_next;
            tally_reg <= s1_emit ? '0 : tally_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire && s1_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_emit) begin
            out_count_reg <= tally_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_count_reg);

endmodule

`default_nettype wire

// ----- src/mlec_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mlec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old word on a same-address write
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- src/mlec_judge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mlec_judge #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic signed [SAMPLE_WIDTH-1:0] center,
    input  wire logic signed [SAMPLE_WIDTH-1:0] nbr [8],
    input  wire logic [7:0]                     mask,
    input  wire logic                           enable,
    output      logic                           hit
);

    logic [7:0] gt;
    logic [7:0] lt;

    // Strictly above or strictly below every neighbor in range
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            gt[k] = center > nbr[k];
            lt[k] = center < nbr[k];
        end
        hit = enable && ((&(~mask | gt)) || (&(~mask | lt)));
    end

endmodule

`default_nettype wire
